>>> src/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; used by bcc_step and button_click_classifier_top.
package bcc_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int BTN_BITS    = 2;
	localparam int TIME_BITS   = 32;
	localparam int CFG_BITS    = 16;
	localparam int KIND_BITS   = 2;
	localparam int CLICK_BITS  = 2;

	// event kinds
	localparam logic [KIND_BITS-1:0] KIND_SHORT  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_LONG   = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_DOUBLE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_LONG     = 2'd1;
	localparam logic [1:0] REG_DOUBLE   = 2'd2;

	localparam logic [CLICK_BITS-1:0] DOUBLE_CLICK_COUNT = 2'd2;

	typedef struct packed {
		logic                  raw_level;
		logic                  stable_level;
		logic                  long_sent;
		logic                  tracking;
		logic [CLICK_BITS-1:0] clicks;
		logic [TIME_BITS-1:0]  raw_change_time;
		logic [TIME_BITS-1:0]  press_time;
		logic [TIME_BITS-1:0]  release_time;
	} btn_state_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] long_press_ms;
		logic [CFG_BITS-1:0] double_click_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic                 have;
		logic [KIND_BITS-1:0] kind;
	} step_event_t;

endpackage

>>> src/bcc_step.sv
// Per-button update logic: debounce, click counting, long press and
// double-click timing for one poll. Combinational; depends on bcc_pkg.
module bcc_step (
	input  bcc_pkg::btn_state_t           cur,
	input  bcc_pkg::cfg_regs_t            cfg,
	input  logic                          press_intr,
	input  logic                          pressed_level,
	input  logic [bcc_pkg::TIME_BITS-1:0] now_ms,
	output bcc_pkg::btn_state_t           nxt,
	output bcc_pkg::step_event_t          evt
);

	logic [bcc_pkg::TIME_BITS-1:0] deb_t;
	logic [bcc_pkg::TIME_BITS-1:0] long_t;
	logic [bcc_pkg::TIME_BITS-1:0] dbl_t;

	assign deb_t  = bcc_pkg::TIME_BITS'(cfg.debounce_ms);
	assign long_t = bcc_pkg::TIME_BITS'(cfg.long_press_ms);
	assign dbl_t  = bcc_pkg::TIME_BITS'(cfg.double_click_ms);

	always_comb begin
		bcc_pkg::btn_state_t s;
		s = cur;
		evt.have = 1'b0;
		evt.kind = bcc_pkg::KIND_SHORT;

		if (press_intr) begin
			s.tracking = 1'b1;
			if (!s.raw_level && !s.stable_level) begin
				s.raw_level       = 1'b1;
				s.raw_change_time = now_ms;
			end
		end

		// idle, untracked button: poll leaves state untouched
		if (!(s.tracking || s.raw_level || s.stable_level || s.clicks != '0)) begin
			s = cur;
		end else begin
			if (pressed_level != s.raw_level) begin
				s.raw_level       = pressed_level;
				s.raw_change_time = now_ms;
			end

			if (s.raw_level != s.stable_level &&
			    (now_ms - s.raw_change_time) >= deb_t) begin
				s.stable_level = s.raw_level;
				if (s.stable_level) begin
					s.tracking   = 1'b1;
					s.press_time = now_ms;
					s.long_sent  = 1'b0;
				end else if (!s.long_sent) begin
					s.clicks       = s.clicks + 1'b1;
					s.release_time = now_ms;
					if (s.clicks >= bcc_pkg::DOUBLE_CLICK_COUNT) begin
						evt.have = 1'b1;
						evt.kind = bcc_pkg::KIND_DOUBLE;
						s.clicks = '0;
					end
				end else begin
					s.clicks = '0;
				end
			end

			if (s.stable_level && !s.long_sent &&
			    (now_ms - s.press_time) >= long_t) begin
				evt.have    = 1'b1;
				evt.kind    = bcc_pkg::KIND_LONG;
				s.long_sent = 1'b1;
				s.clicks    = '0;
			end

			// lone click: report once the double-click window has run out
			if (!s.stable_level && s.clicks == 2'd1 &&
			    (now_ms - s.release_time) >= dbl_t) begin
				evt.have = 1'b1;
				evt.kind = bcc_pkg::KIND_SHORT;
				s.clicks = '0;
			end

			if (!s.stable_level && !s.raw_level && s.clicks == '0 &&
			    (now_ms - s.raw_change_time) >= deb_t) begin
				s.tracking = 1'b0;
			end
		end

		nxt = s;
	end

endmodule

>>> src/button_click_classifier_top.sv
// Top level of the button click classifier: input register, per-button
// state registers, output register. Depends on bcc_pkg and bcc_step.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one poll of one button:
//    button_index, press_intr, pressed_level, now_ms. A transaction happens
//    at a rising edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall) carries zero or one event per
//    poll: event_button, event_kind (0 short, 1 long, 2 double), event_time.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//    debounce_ms (0), long_press_ms (1), double_click_ms (2). cfg_ready is
//    always high; index 3 is ignored. Write only while the block is idle.
//  - Flow: an accepted poll sits in the input register; when it retires it
//    updates its button's state register and, if it makes an event, loads
//    the output register, from which the receiver takes it.
//  - Throughput: one poll per cycle while in_stall is low, set by the
//    read-modify-write of the addressed button's state register.
//  - When out_stall holds an event, a poll that makes no event still
//    retires; a poll that makes an event waits in the input register, and
//    in_stall rises until the output register frees.
//  - Reset (arst_n low) clears all button state, restores the threshold
//    defaults (20, 1000, 300 ms) and empties both registers.
module button_click_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bcc_pkg::BTN_BITS-1:0]  button_index,
	input  logic                          press_intr,
	input  logic                          pressed_level,
	input  logic [bcc_pkg::TIME_BITS-1:0] now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcc_pkg::BTN_BITS-1:0]  event_button,
	output logic [bcc_pkg::KIND_BITS-1:0] event_kind,
	output logic [bcc_pkg::TIME_BITS-1:0] event_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [bcc_pkg::CFG_BITS-1:0]  cfg_data
);

	bcc_pkg::cfg_regs_t   cfg_q;
	bcc_pkg::btn_state_t  state_q [bcc_pkg::NUM_BUTTONS];
	bcc_pkg::btn_state_t  cur_state;
	bcc_pkg::btn_state_t  nxt_state;
	bcc_pkg::step_event_t evt;

	logic                          valid_s1;
	logic [bcc_pkg::BTN_BITS-1:0]  btn_s1;
	logic                          irq_s1;
	logic                          level_s1;
	logic [bcc_pkg::TIME_BITS-1:0] now_s1;

	logic                          out_valid_q;
	logic [bcc_pkg::BTN_BITS-1:0]  out_btn_q;
	logic [bcc_pkg::KIND_BITS-1:0] out_kind_q;
	logic [bcc_pkg::TIME_BITS-1:0] out_time_q;

	logic s1_go;
	logic in_take;
	logic out_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= 16'd20;
			cfg_q.long_press_ms   <= 16'd1000;
			cfg_q.double_click_ms <= 16'd300;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bcc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				bcc_pkg::REG_LONG:     cfg_q.long_press_ms   <= cfg_data;
				bcc_pkg::REG_DOUBLE:   cfg_q.double_click_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// poll in s1 retires unless it has an event and the output is blocked
	assign out_take = out_valid_q && !out_stall;
	assign s1_go    = valid_s1 && !(evt.have && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			btn_s1   <= button_index;
			irq_s1   <= press_intr;
			level_s1 <= pressed_level;
			now_s1   <= now_ms;
		end
	end

	assign cur_state = state_q[btn_s1];

	bcc_step u_step (
		.cur           (cur_state),
		.cfg           (cfg_q),
		.press_intr    (irq_s1),
		.pressed_level (level_s1),
		.now_ms        (now_s1),
		.nxt           (nxt_state),
		.evt           (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcc_pkg::NUM_BUTTONS; i++) begin
				state_q[i] <= '0;
			end
		end else if (s1_go) begin
			state_q[btn_s1] <= nxt_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && evt.have) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && evt.have) begin
			out_btn_q  <= btn_s1;
			out_kind_q <= evt.kind;
			out_time_q <= now_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_button = out_btn_q;
	assign event_kind   = out_kind_q;
	assign event_time   = out_time_q;

endmodule
